// ===== sv/ps2m_pkg.sv =====
// ps2m_pkg: shared constants for the ps/2 mouse packet cursor tracker
// register indexes, field widths, reset sizes and header bit positions
// no dependencies
package ps2m_pkg;

  // coordinate width default and configuration register width
  localparam int COORD_BITS_DEF = 12;
  localparam int CFG_BITS       = 13;
  localparam int CFG_IDX_BITS   = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

  // screen size after reset
  localparam int RESET_WIDTH  = 800;
  localparam int RESET_HEIGHT = 600;

  // header byte bit positions
  localparam int HDR_LEFT_BIT  = 0;
  localparam int HDR_RIGHT_BIT = 1;
  localparam int HDR_SYNC_BIT  = 3;
  localparam int HDR_XSIGN_BIT = 4;
  localparam int HDR_YSIGN_BIT = 5;

endpackage

// ===== sv/ps2_mouse_packet_cursor_tracker.sv =====
// Cursor tracker fed by a ps/2 controller byte stream. Bytes not tagged as
// coming from the aux port are ignored; mouse bytes are gathered into
// three-byte packets (header, x delta, y delta), and a header without bit 3
// set is dropped to regain sync. A completed packet moves the cursor by the
// sign-extended 9-bit deltas (y subtracted, so y grows downward), clamps each
// axis to 0..size-1 and latches the left and right buttons. Every accepted
// byte gives exactly one result item in the next cycle, carrying the cursor,
// the buttons and packet_done. One byte is taken every cycle unless a
// result waits untaken: the only logic between the packet state and the
// result register is one add and one clamp per axis. Writing screen_width
// or screen_height recenters that axis; a size of 0 acts as 1 and a size
// above 2**COORD_BITS acts as 2**COORD_BITS. Depends on ps2m_pkg.
module ps2_mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // input item channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              from_aux,
  input  logic [7:0]                        data_byte,
  // result item channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [COORD_BITS-1:0]             cursor_x,
  output logic [COORD_BITS-1:0]             cursor_y,
  output logic                              left_button,
  output logic                              right_button,
  output logic                              packet_done,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ps2m_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ps2m_pkg::CFG_BITS-1:0]     cfg_data
);
  import ps2m_pkg::*;

  localparam int EFF_W = COORD_BITS + 1;
  localparam int SZ_W  = (CFG_BITS > EFF_W) ? CFG_BITS : EFF_W;
  localparam int SUM_W = COORD_BITS + 2;

  localparam logic [SZ_W-1:0] SIZE_LIMIT = {{(SZ_W-1){1'b0}}, 1'b1} << COORD_BITS;
  localparam logic [SZ_W-1:0] RST_W_EXT  = SZ_W'(RESET_WIDTH);
  localparam logic [SZ_W-1:0] RST_H_EXT  = SZ_W'(RESET_HEIGHT);
  localparam logic [EFF_W-1:0] RST_EFF_X =
    EFF_W'((RST_W_EXT > SIZE_LIMIT) ? SIZE_LIMIT : RST_W_EXT);
  localparam logic [EFF_W-1:0] RST_EFF_Y =
    EFF_W'((RST_H_EXT > SIZE_LIMIT) ? SIZE_LIMIT : RST_H_EXT);
  localparam logic [COORD_BITS-1:0] RST_POS_X = COORD_BITS'(RST_EFF_X >> 1);
  localparam logic [COORD_BITS-1:0] RST_POS_Y = COORD_BITS'(RST_EFF_Y >> 1);

  // byte position codes
  localparam logic [1:0] BP_HEADER = 2'd0;
  localparam logic [1:0] BP_XDELTA = 2'd1;
  localparam logic [1:0] BP_YDELTA = 2'd2;

  // packet state
  logic [1:0]            byte_position, byte_position_next;
  logic [7:0]            header_byte, x_delta_byte;
  logic [COORD_BITS-1:0] pos_x, pos_x_next;
  logic [COORD_BITS-1:0] pos_y, pos_y_next;
  logic                  left_state, left_state_next;
  logic                  right_state, right_state_next;
  logic                  done_next;
  logic [EFF_W-1:0]      eff_x, eff_y;

  logic                  in_accept, cfg_accept;
  logic [SZ_W-1:0]       cfg_ext;
  logic [EFF_W-1:0]      cfg_eff;
  logic [8:0]            dx, dy;
  logic signed [SUM_W-1:0] nx, ny;
  logic [EFF_W-1:0]      max_x, max_y;
  logic [COORD_BITS-1:0] clamp_x, clamp_y;

  // handshakes: the result register frees up as it is taken
  assign in_ready   = !out_valid || out_ready;
  assign in_accept  = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign cfg_accept = cfg_valid && cfg_ready;

  // effective size of the written register value
  always_comb begin
    cfg_ext = SZ_W'(cfg_data);
    if (cfg_data == '0) begin
      cfg_eff = EFF_W'(1);
    end else if (cfg_ext > SIZE_LIMIT) begin
      cfg_eff = EFF_W'(SIZE_LIMIT);
    end else begin
      cfg_eff = EFF_W'(cfg_ext);
    end
  end

  // sign-extended deltas and new positions
  assign dx    = {header_byte[HDR_XSIGN_BIT], x_delta_byte};
  assign dy    = {header_byte[HDR_YSIGN_BIT], data_byte};
  assign nx    = $signed({2'b00, pos_x}) + $signed({{(SUM_W-9){dx[8]}}, dx});
  assign ny    = $signed({2'b00, pos_y}) - $signed({{(SUM_W-9){dy[8]}}, dy});
  assign max_x = eff_x - EFF_W'(1);
  assign max_y = eff_y - EFF_W'(1);

  // clamp to 0..size-1
  always_comb begin
    if (nx[SUM_W-1]) begin
      clamp_x = '0;
    end else if (nx[EFF_W-1:0] >= eff_x) begin
      clamp_x = max_x[COORD_BITS-1:0];
    end else begin
      clamp_x = nx[COORD_BITS-1:0];
    end
    if (ny[SUM_W-1]) begin
      clamp_y = '0;
    end else if (ny[EFF_W-1:0] >= eff_y) begin
      clamp_y = max_y[COORD_BITS-1:0];
    end else begin
      clamp_y = ny[COORD_BITS-1:0];
    end
  end

  // packet assembly
  always_comb begin
    byte_position_next = byte_position;
    pos_x_next         = pos_x;
    pos_y_next         = pos_y;
    left_state_next    = left_state;
    right_state_next   = right_state;
    done_next          = 1'b0;
    if (from_aux) begin
      case (byte_position)
        BP_HEADER: begin
          if (data_byte[HDR_SYNC_BIT]) begin
            byte_position_next = BP_XDELTA;
          end
        end
        BP_XDELTA: begin
          byte_position_next = BP_YDELTA;
        end
        default: begin
          pos_x_next         = clamp_x;
          pos_y_next         = clamp_y;
          left_state_next    = header_byte[HDR_LEFT_BIT];
          right_state_next   = header_byte[HDR_RIGHT_BIT];
          byte_position_next = BP_HEADER;
          done_next          = 1'b1;
        end
      endcase
    end
  end

  // control state, sizes and cursor
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= BP_HEADER;
      pos_x         <= RST_POS_X;
      pos_y         <= RST_POS_Y;
      eff_x         <= RST_EFF_X;
      eff_y         <= RST_EFF_Y;
      left_state    <= 1'b0;
      right_state   <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_accept) begin
        case (cfg_index)
          REG_SCREEN_WIDTH: begin
            eff_x <= cfg_eff;
            pos_x <= COORD_BITS'(cfg_eff >> 1);
          end
          REG_SCREEN_HEIGHT: begin
            eff_y <= cfg_eff;
            pos_y <= COORD_BITS'(cfg_eff >> 1);
          end
          default: begin
          end
        endcase
      end
      if (in_accept) begin
        byte_position <= byte_position_next;
        pos_x         <= pos_x_next;
        pos_y         <= pos_y_next;
        left_state    <= left_state_next;
        right_state   <= right_state_next;
        out_valid     <= 1'b1;
      end else if (out_ready) begin
        out_valid     <= 1'b0;
      end
    end
  end

  // stored packet bytes and result payload
  always_ff @(posedge clk) begin
    if (in_accept && from_aux) begin
      if (byte_position == BP_HEADER && data_byte[HDR_SYNC_BIT]) begin
        header_byte <= data_byte;
      end
      if (byte_position == BP_XDELTA) begin
        x_delta_byte <= data_byte;
      end
    end
    if (in_accept) begin
      cursor_x     <= pos_x_next;
      cursor_y     <= pos_y_next;
      left_button  <= left_state_next;
      right_button <= right_state_next;
      packet_done  <= done_next;
    end
  end

endmodule

// ===== sv/ps2m_checker.sv =====
// ps2m_checker: port-level checks for the ps/2 mouse cursor tracker
// bound to ps2_mouse_packet_cursor_tracker; depends on ps2m_pkg
module ps2m_checker #(
  parameter int COORD_BITS = ps2m_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  from_aux,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [COORD_BITS-1:0] cursor_x,
  input logic [COORD_BITS-1:0] cursor_y,
  input logic                  packet_done
);
  import ps2m_pkg::*;

  // every accepted item gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted item gave no result");

  // an empty result register never stalls the input
  a_no_idle_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with no result pending");

  // a byte from the keyboard port never completes a packet
  a_non_aux_no_done: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !from_aux |=> !packet_done)
    else $error("packet_done on a non-mouse byte");

  // a stalled result item holds its cursor
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y))
    else $error("stalled result changed");

endmodule

bind ps2_mouse_packet_cursor_tracker ps2m_checker #(.COORD_BITS(COORD_BITS)) u_ps2m_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .from_aux    (from_aux),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .cursor_x    (cursor_x),
  .cursor_y    (cursor_y),
  .packet_done (packet_done)
);

// ===== test/tb.sv =====
// testbench for ps2_mouse_packet_cursor_tracker: random and directed byte streams
// with a scoreboard that tracks packets, cursor and buttons, and checks every result item
// depends on ps2m_pkg and the tracker rtl
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2m_pkg::*;

  localparam int CB = COORD_BITS_DEF;
  localparam int STALL_LIMIT = 2000;
  localparam int SQUEEZE_CYCLES = 200;

  // indexes with no register behind them
  localparam logic [CFG_IDX_BITS-1:0] REG_NONE_LO = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NONE_HI = 2'd3;

  typedef struct packed {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          left;
    logic          right;
    logic          done;
  } cursor_report_t;

  typedef enum bit [1:0] {AT_HEADER, AT_X, AT_Y} pkt_slot_t;

  // tracks packet assembly and cursor motion, holds the expected result items
  class cursor_scoreboard;
    int unsigned    width_reg;
    int unsigned    height_reg;
    pkt_slot_t      slot;
    bit [7:0]       hdr_byte;
    bit [7:0]       dx_byte;
    bit [CB-1:0]    cur_x;
    bit [CB-1:0]    cur_y;
    bit             btn_l;
    bit             btn_r;
    cursor_report_t expected_reports[$];
    int unsigned    errors;

    function int unsigned axis_span(int unsigned size);
      if (size == 0) return 1;
      if (size > (1 << CB)) return 1 << CB;
      return size;
    endfunction

    function bit [CB-1:0] fit_axis(int v, int unsigned span);
      if (v < 0) return '0;
      if (v >= int'(span)) return CB'(span - 1);
      return CB'(v);
    endfunction

    function void clear();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      slot       = AT_HEADER;
      hdr_byte   = '0;
      dx_byte    = '0;
      cur_x      = CB'(axis_span(width_reg) / 2);
      cur_y      = CB'(axis_span(height_reg) / 2);
      btn_l      = 1'b0;
      btn_r      = 1'b0;
      errors     = 0;
      expected_reports.delete();
    endfunction

    // a size write recenters its axis; other indexes do nothing
    function void write_size(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
      if (idx == REG_SCREEN_WIDTH) begin
        width_reg = 32'(val);
        cur_x = CB'(axis_span(width_reg) / 2);
      end else if (idx == REG_SCREEN_HEIGHT) begin
        height_reg = 32'(val);
        cur_y = CB'(axis_span(height_reg) / 2);
      end
    endfunction

    // accepted input byte: advance the packet and queue the result item it yields
    function void note_byte(bit aux, bit [7:0] b);
      int dx;
      int dy;
      bit done;
      cursor_report_t r;
      done = 1'b0;
      if (aux) begin
        case (slot)
          AT_HEADER: begin
            if (b[HDR_SYNC_BIT]) begin
              hdr_byte = b;
              slot = AT_X;
            end
          end
          AT_X: begin
            dx_byte = b;
            slot = AT_Y;
          end
          default: begin
            dx = hdr_byte[HDR_XSIGN_BIT] ? int'(dx_byte) - 256 : int'(dx_byte);
            dy = hdr_byte[HDR_YSIGN_BIT] ? int'(b) - 256 : int'(b);
            cur_x = fit_axis(int'(cur_x) + dx, axis_span(width_reg));
            cur_y = fit_axis(int'(cur_y) - dy, axis_span(height_reg));
            btn_l = hdr_byte[HDR_LEFT_BIT];
            btn_r = hdr_byte[HDR_RIGHT_BIT];
            slot  = AT_HEADER;
            done  = 1'b1;
          end
        endcase
      end
      r.x     = cur_x;
      r.y     = cur_y;
      r.left  = btn_l;
      r.right = btn_r;
      r.done  = done;
      expected_reports.push_back(r);
    endfunction

    function void check_field(string what, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
        errors++;
      end
    endfunction

    // accepted result item against the oldest expectation
    function void check_report(logic [CB-1:0] x, logic [CB-1:0] y, logic l, logic r,
                               logic done);
      cursor_report_t want;
      if (expected_reports.size() == 0) begin
        $display("%0t: result item with none expected, x %0d y %0d", $time, x, y);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      check_field("cursor_x", want.x, x);
      check_field("cursor_y", want.y, y);
      check_field("left_button", want.left, l);
      check_field("right_button", want.right, r);
      check_field("packet_done", want.done, done);
    endfunction

    function int unsigned pending();
      return expected_reports.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst;
  logic                    in_valid;
  logic                    in_ready;
  logic                    from_aux;
  logic [7:0]              data_byte;
  logic                    out_valid;
  logic                    out_ready;
  logic [CB-1:0]           cursor_x;
  logic [CB-1:0]           cursor_y;
  logic                    left_button;
  logic                    right_button;
  logic                    packet_done;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]     cfg_data;

  cursor_scoreboard sb;
  bit               calm = 1'b0;
  bit               squeeze_req = 1'b0;
  int unsigned      mouse_bytes_sent = 0;
  int unsigned      stall_cycles = 0;
  bit [1:0]         drift_sign;

  ps2_mouse_packet_cursor_tracker dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .from_aux    (from_aux),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .cursor_x    (cursor_x),
    .cursor_y    (cursor_y),
    .left_button (left_button),
    .right_button(right_button),
    .packet_done (packet_done),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_report(cursor_x, cursor_y, left_button, right_button, packet_done);
  end

  // watchdog on cycles with no handshake on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // receiver: ready stretches, short stalls, and one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      if (squeeze_req) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat (SQUEEZE_CYCLES - 1) @(negedge clk);
        squeeze_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        @(negedge clk);
        out_ready = 1'b0;
        repeat ($urandom_range(0, 7)) @(negedge clk);
      end else begin
        @(negedge clk);
        out_ready = 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  // offer one byte, with an optional idle burst first, and wait for acceptance
  task automatic send_byte(input bit aux, input bit [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!calm && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 8);
    repeat (gap) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    from_aux  = aux;
    data_byte = b;
    do @(posedge clk); while (!in_ready);
    sb.note_byte(aux, b);
    if (aux) mouse_bytes_sent++;
  endtask

  // mouse byte, now and then preceded by a keyboard byte
  task automatic send_mouse_byte(input bit [7:0] b);
    if ($urandom_range(0, 11) == 0) send_byte(1'b0, 8'($urandom_range(0, 255)));
    send_byte(1'b1, b);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_size(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic bit [7:0] header_of(bit l, bit r, bit xneg, bit yneg);
    bit [7:0] h;
    h = '0;
    h[HDR_SYNC_BIT]  = 1'b1;
    h[HDR_LEFT_BIT]  = l;
    h[HDR_RIGHT_BIT] = r;
    h[HDR_XSIGN_BIT] = xneg;
    h[HDR_YSIGN_BIT] = yneg;
    return h;
  endfunction

  // delta byte: full scale in the drift direction half the time
  function automatic bit [7:0] delta_of(bit neg);
    if ($urandom_range(0, 1) == 0) return neg ? 8'h00 : 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // one unit of random traffic: mostly whole packets, some broken ones and noise
  task automatic send_traffic_unit();
    int unsigned pick;
    bit [7:0]    hdr;
    pick = $urandom_range(0, 99);
    hdr  = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 1) == 0) begin
      hdr[HDR_XSIGN_BIT] = drift_sign[0];
      hdr[HDR_YSIGN_BIT] = drift_sign[1];
    end
    if (pick < 80) begin
      hdr[HDR_SYNC_BIT] = 1'b1;
      send_mouse_byte(hdr);
      send_mouse_byte(delta_of(hdr[HDR_XSIGN_BIT]));
      send_mouse_byte(delta_of(hdr[HDR_YSIGN_BIT]));
    end else if (pick < 88) begin
      // header out of sync, dropped
      hdr[HDR_SYNC_BIT] = 1'b0;
      send_byte(1'b1, hdr);
    end else if (pick < 94) begin
      // truncated packet, stream slips
      hdr[HDR_SYNC_BIT] = 1'b1;
      send_mouse_byte(hdr);
      if ($urandom_range(0, 1) == 0) send_mouse_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 4)) send_byte(1'b0, 8'($urandom_range(0, 255)));
    end
  endtask

  // idle point: new sizes, unused indexes, then random traffic
  task automatic run_phase(input logic [CFG_BITS-1:0] w, input logic [CFG_BITS-1:0] h,
                           input int unsigned quota, input bit squeeze);
    int unsigned target;
    wait_drain();
    write_reg(REG_SCREEN_WIDTH, w);
    write_reg(REG_NONE_LO, CFG_BITS'($urandom_range(0, 8191)));
    write_reg(REG_SCREEN_HEIGHT, h);
    write_reg(REG_NONE_HI, CFG_BITS'($urandom_range(0, 8191)));
    drift_sign = 2'($urandom_range(0, 3));
    if (squeeze) squeeze_req = 1'b1;
    target = mouse_bytes_sent + quota;
    while (mouse_bytes_sent < target) send_traffic_unit();
  endtask

  initial begin
    sb = new();
    sb.clear();
    rst       = 1'b1;
    in_valid  = 1'b0;
    from_aux  = 1'b0;
    data_byte = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_SCREEN_WIDTH;
    cfg_data  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: keyboard bytes, bad headers, full-scale deltas, buttons
    send_byte(1'b0, 8'hFF);
    send_byte(1'b0, 8'h00);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'hF7);
    send_byte(1'b1, header_of(1'b0, 1'b0, 1'b0, 1'b0));
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, header_of(1'b1, 1'b1, 1'b0, 1'b0));
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b1, header_of(1'b0, 1'b0, 1'b1, 1'b1));
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, header_of(1'b1, 1'b0, 1'b0, 1'b1));
    send_byte(1'b1, 8'h80);
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, header_of(1'b0, 1'b1, 1'b1, 1'b1));
    send_byte(1'b1, 8'h00);
    send_byte(1'b1, 8'h01);
    send_byte(1'b1, 8'hFF);
    send_byte(1'b0, 8'h5A);
    send_byte(1'b1, 8'h00);
    send_byte(1'b0, 8'hA5);
    send_byte(1'b1, 8'h80);

    // random phases across size settings
    run_phase(13'd0, 13'd0, 120, 1'b0);
    run_phase(13'd1, 13'd1, 100, 1'b0);
    run_phase(13'd4096, 13'd4096, 150, 1'b1);
    run_phase(13'd8191, 13'd4097, 120, 1'b0);
    run_phase(13'd7, 13'd3, 120, 1'b0);
    run_phase(CFG_BITS'($urandom_range(1, 4096)), CFG_BITS'($urandom_range(1, 4096)),
              150, 1'b0);
    run_phase(13'd2, 13'd4095, 100, 1'b0);
    calm = 1'b1;
    run_phase(CFG_BITS'(RESET_WIDTH), CFG_BITS'(RESET_HEIGHT), 150, 1'b0);

    wait_drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
